>>> hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> hw/rtl/ktli_pkg.sv
// Shared types, constants and command codes of the keyed table interpolator.
package ktli_pkg;
   localparam int TABLE_ROWS = 1024;
   localparam int NUM_VALUES = 20;
   localparam int ROW_W = $clog2(TABLE_ROWS);
   localparam int CNT_W = ROW_W + 1;
   localparam int COL_W = 5;
   localparam int VAL_DEPTH = TABLE_ROWS * NUM_VALUES;
   localparam int VAL_AW = $clog2(VAL_DEPTH);
   localparam int QDEPTH = 2;

   localparam logic [1:0] CMD_KEYS = 2'd0;
   localparam logic [1:0] CMD_VALUE = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0] cmd;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [7:0] charge;
      logic [31:0] energy;
      logic [31:0] data;
   } item_type;
endpackage

>>> hw/rtl/keyed_table_linear_interpolator.sv
// Top level of the keyed table interpolator.
//  channel  | ports                         | handshake
//  request  | req_*                         | start && !busy
//  result   | rsp_*                         | rsp_valid, one cycle
//  csr      | csr_*                         | csr_wr_en
// Writes retire as they are popped from the queue while idle; a lookup runs binary searches
// of up to 11 steps, one for each charge bound and, when the charge is found, one for the
// energy, then fetches the bracketing energies and per value copies a table word or
// interpolates it through the 64-step divider; a missing charge gives one zero word a cycle.
// Reset is synchronous. A two-word queue parts front from back; the receiver cannot stall.
`include "assert_macros.svh"
module keyed_table_linear_interpolator (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_cmd,
   input logic [9:0] req_row_index,
   input logic [4:0] req_value_column,
   input logic [7:0] req_charge_key,
   input logic [31:0] req_energy_key,
   input logic signed [31:0] req_data_value,
   input logic csr_wr_en,
   input logic [10:0] csr_wr_data,
   output logic rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [4:0] rsp_result_column,
   output logic rsp_found,
   output logic rsp_last
);
   import ktli_pkg::*;
   logic [10:0] rows_ff;
   logic pop, q_valid;
   item_type q_item;
   logic [31:0] rv;
   always_ff @(posedge clock) begin
      if (reset) rows_ff <= '0;
      else if (csr_wr_en) rows_ff <= csr_wr_data;
   end
   ktli_front u_front (.clock, .reset, .start, .busy, .req_cmd, .req_row_index,
      .req_value_column, .req_charge_key, .req_energy_key,
      .req_data_value(req_data_value), .pop, .q_valid, .q_item);
   ktli_back u_back (.clock, .reset, .rows_in_use(rows_ff), .q_valid, .q_item, .pop,
      .rsp_valid, .rsp_result_value(rv), .rsp_result_column, .rsp_found, .rsp_last);
   assign rsp_result_value = rv;

   `ASSERT_IMPL(a_pop_valid, clock, reset, pop, q_valid, "pop from empty queue")
   `ASSERT_IMPL(a_nf_zero, clock, reset, rsp_valid && !rsp_found, rv == 32'd0,
      "missing charge gave nonzero value")
   `ASSERT_IMPL(a_last_col, clock, reset, rsp_valid && rsp_last,
      rsp_result_column == 5'(NUM_VALUES - 1), "last on wrong column")
endmodule

>>> hw/rtl/ktli_ram.sv
// Generic single-port write, single-port registered-read RAM.
module ktli_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] wr_addr,
   input logic [WIDTH-1:0] wr_data,
   input logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/ktli_front.sv
// Front end: takes command words, drops unknown ones and out-of-range value columns, feeds the queue.
module ktli_front (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_cmd,
   input logic [9:0] req_row_index,
   input logic [4:0] req_value_column,
   input logic [7:0] req_charge_key,
   input logic [31:0] req_energy_key,
   input logic [31:0] req_data_value,
   input logic pop,
   output logic q_valid,
   output ktli_pkg::item_type q_item
);
   import ktli_pkg::*;
   item_type q_ff [QDEPTH];
   logic [0:0] rp_ff, wp_ff;
   logic [1:0] cnt_ff;
   logic push, keep;
   item_type it;
   assign busy = (cnt_ff == 2'(QDEPTH));
   always_comb begin
      it.cmd = req_cmd;
      it.row = ROW_W'(req_row_index);
      it.col = req_value_column;
      it.charge = req_charge_key;
      it.energy = req_energy_key;
      it.data = req_data_value;
   end
   // drop unknown commands and out-of-range columns here
   assign keep = (req_cmd == CMD_KEYS) || (req_cmd == CMD_LOOKUP) ||
                 (req_cmd == CMD_VALUE && req_value_column < COL_W'(NUM_VALUES));
   assign push = start && !busy && keep;
   assign q_valid = (cnt_ff != 2'd0);
   assign q_item = q_ff[rp_ff];
   always_ff @(posedge clock) begin
      if (push) q_ff[wp_ff] <= it;
      if (reset) begin
         rp_ff <= '0; wp_ff <= '0; cnt_ff <= '0;
      end else begin
         if (push) wp_ff <= wp_ff + 1'b1;
         if (pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + 2'(push) - 2'(pop);
      end
   end
endmodule

>>> hw/rtl/ktli_divider.sv
// Restoring divider for unsigned 64 by 33 bits, one quotient bit a cycle.
module ktli_divider (
   input logic clock,
   input logic reset,
   input logic go,
   input logic [63:0] dividend,
   input logic [32:0] divisor,
   output logic done,
   output logic [63:0] quotient
);
   logic [63:0] q_ff;
   logic [33:0] r_ff;
   logic [32:0] d_ff;
   logic [6:0] n_ff;
   logic run_ff, done_ff;
   logic [33:0] sh;
   assign sh = {r_ff[32:0], q_ff[63]};
   assign done = done_ff;
   assign quotient = q_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0; done_ff <= 1'b0; n_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (go) begin
            run_ff <= 1'b1; n_ff <= 7'd0;
            q_ff <= dividend; r_ff <= '0; d_ff <= divisor;
         end else if (run_ff) begin
            if (sh >= {1'b0, d_ff}) begin
               r_ff <= sh - {1'b0, d_ff};
               q_ff <= {q_ff[62:0], 1'b1};
            end else begin
               r_ff <= sh;
               q_ff <= {q_ff[62:0], 1'b0};
            end
            n_ff <= n_ff + 7'd1;
            if (n_ff == 7'd63) begin
               run_ff <= 1'b0; done_ff <= 1'b1;
            end
         end
      end
   end
endmodule

>>> hw/rtl/ktli_back.sv
// Back end: table writes, binary searches and interpolation sequencer.
module ktli_back (
   input logic clock,
   input logic reset,
   input logic [10:0] rows_in_use,
   input logic q_valid,
   input ktli_pkg::item_type q_item,
   output logic pop,
   output logic rsp_valid,
   output logic [31:0] rsp_result_value,
   output logic [4:0] rsp_result_column,
   output logic rsp_found,
   output logic rsp_last
);
   import ktli_pkg::*;
   localparam logic [3:0] S_IDLE = 4'd0, S_SPROBE = 4'd1, S_SWAIT = 4'd2,
      S_SCMP = 4'd3, S_PICK = 4'd4, S_PWAIT = 4'd5, S_PCMP = 4'd6,
      S_VRD = 4'd7, S_VWAIT = 4'd8, S_VCMP = 4'd9, S_MUL = 4'd10,
      S_DIV = 4'd11, S_OUT = 4'd12, S_DGO = 4'd13;
   localparam logic [1:0] M_CHARGE_LO = 2'd0, M_CHARGE_HI = 2'd1, M_ENERGY = 2'd2;

   logic [3:0] st_ff;
   item_type it_ff;
   logic [1:0] mode_ff;
   logic [CNT_W-1:0] first_ff, count_ff, lo_ff, hi_ff, e_ff, n;
   logic [ROW_W-1:0] probe_ff, src_ff;
   logic copy_ff, found_ff;
   logic [31:0] x1_ff, x2_ff, f1_ff, f2_ff;
   logic [COL_W-1:0] col_ff;
   logic [63:0] prod_ff;
   logic neg_ff;
   logic [31:0] out_ff;
   logic ov_ff, last_ff, fo_ff;
   logic [COL_W-1:0] ocol_ff;

   logic [ROW_W-1:0] k_addr;
   logic [7:0] ch_rd;
   logic [31:0] en_rd, va_rd;
   logic [VAL_AW-1:0] v_addr, w_addr;
   logic [ROW_W-1:0] v_row;
   logic keys_we, val_we;

   assign n = (rows_in_use > 11'(TABLE_ROWS)) ? CNT_W'(TABLE_ROWS) : CNT_W'(rows_in_use);
   assign keys_we = (st_ff == S_IDLE) && q_valid && q_item.cmd == CMD_KEYS;
   assign val_we = (st_ff == S_IDLE) && q_valid && q_item.cmd == CMD_VALUE;
   assign pop = (st_ff == S_IDLE) && q_valid;
   assign w_addr = VAL_AW'(q_item.row * NUM_VALUES + q_item.col);
   assign v_addr = VAL_AW'(v_row * NUM_VALUES + col_ff);

   ktli_ram #(.WIDTH(8), .DEPTH(TABLE_ROWS)) u_ch (.clock, .wr_en(keys_we),
      .wr_addr(q_item.row), .wr_data(q_item.charge), .rd_addr(k_addr), .rd_data(ch_rd));
   ktli_ram #(.WIDTH(32), .DEPTH(TABLE_ROWS)) u_en (.clock, .wr_en(keys_we),
      .wr_addr(q_item.row), .wr_data(q_item.energy), .rd_addr(k_addr), .rd_data(en_rd));
   ktli_ram #(.WIDTH(32), .DEPTH(VAL_DEPTH)) u_va (.clock, .wr_en(val_we),
      .wr_addr(w_addr), .wr_data(q_item.data), .rd_addr(v_addr), .rd_data(va_rd));

   // divider
   logic dgo, ddone;
   logic [63:0] quo;
   ktli_divider u_div (.clock, .reset, .go(dgo), .dividend(prod_ff),
      .divisor({1'b0, x2_ff} - {1'b0, x1_ff}), .done(ddone), .quotient(quo));
   assign dgo = (st_ff == S_DGO);

   logic [CNT_W-1:0] step;
   logic probe_low;
   assign step = count_ff >> 1;
   always_comb begin
      case (mode_ff)
         M_CHARGE_LO: probe_low = ch_rd < it_ff.charge;
         M_CHARGE_HI: probe_low = ch_rd <= it_ff.charge;
         default: probe_low = en_rd < it_ff.energy;
      endcase
   end
   always_comb begin
      case (st_ff)
         S_PWAIT, S_PCMP: k_addr = ROW_W'(e_ff - 1'b1);
         default: k_addr = probe_ff;
      endcase
   end
   assign v_row = (st_ff == S_VRD && copy_ff) ? src_ff :
                  (st_ff == S_VRD) ? ROW_W'(e_ff - 1'b1) : ROW_W'(e_ff);

   // lerp combinational parts
   logic signed [32:0] df, tt;
   logic [32:0] mdf, mt;
   logic signed [34:0] r;
   logic [33:0] qc;
   assign df = $signed({f2_ff[31], f2_ff}) - $signed({f1_ff[31], f1_ff});
   assign tt = $signed({1'b0, it_ff.energy}) - $signed({1'b0, x1_ff});
   assign mdf = df[32] ? 33'(-df) : 33'(df);
   assign mt = tt[32] ? 33'(-tt) : 33'(tt);
   assign qc = (quo > 64'h2_0000_0000) ? 34'h2_0000_0000 : quo[33:0];
   assign r = neg_ff ? $signed({{3{f1_ff[31]}}, f1_ff}) - $signed({1'b0, qc})
                     : $signed({{3{f1_ff[31]}}, f1_ff}) + $signed({1'b0, qc});

   assign rsp_valid = ov_ff;
   assign rsp_result_value = out_ff;
   assign rsp_result_column = ocol_ff;
   assign rsp_found = fo_ff;
   assign rsp_last = last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; ov_ff <= 1'b0;
      end else begin
         ov_ff <= 1'b0;
         case (st_ff)
            S_IDLE: if (q_valid && q_item.cmd == CMD_LOOKUP) begin
               it_ff <= q_item; mode_ff <= M_CHARGE_LO;
               first_ff <= '0; count_ff <= n; st_ff <= S_SPROBE;
            end
            S_SPROBE: begin
               if (count_ff == '0) begin
                  // store search result, then advance mode or leave the searches
                  case (mode_ff)
                     M_CHARGE_LO: begin
                        lo_ff <= first_ff; mode_ff <= M_CHARGE_HI;
                        first_ff <= '0; count_ff <= n;
                     end
                     M_CHARGE_HI: begin
                        hi_ff <= first_ff; col_ff <= '0;
                        if (lo_ff >= first_ff) begin
                           found_ff <= 1'b0; st_ff <= S_OUT;
                        end else begin
                           found_ff <= 1'b1; mode_ff <= M_ENERGY;
                           first_ff <= lo_ff; count_ff <= first_ff - lo_ff;
                        end
                     end
                     default: begin
                        e_ff <= first_ff; probe_ff <= ROW_W'(first_ff);
                        st_ff <= S_PICK;
                     end
                  endcase
               end else begin
                  probe_ff <= ROW_W'(first_ff + step); st_ff <= S_SWAIT;
               end
            end
            S_SWAIT: st_ff <= S_SCMP;
            S_SCMP: begin
               if (probe_low) begin
                  first_ff <= first_ff + step + 1'b1;
                  count_ff <= count_ff - step - 1'b1;
               end else count_ff <= step;
               st_ff <= S_SPROBE;
            end
            S_PICK: st_ff <= S_PWAIT;
            S_PWAIT: st_ff <= S_PCMP;
            S_PCMP: begin
               // en_rd holds row e-1, x2 read through probe earlier
               x1_ff <= en_rd; copy_ff <= 1'b0;
               if (e_ff < hi_ff && x2_ff == it_ff.energy) begin
                  copy_ff <= 1'b1; src_ff <= ROW_W'(e_ff);
               end else if (e_ff == lo_ff) begin
                  copy_ff <= 1'b1; src_ff <= ROW_W'(lo_ff);
               end else if (e_ff >= hi_ff) begin
                  copy_ff <= 1'b1; src_ff <= ROW_W'(hi_ff - 1'b1);
               end else if (x2_ff <= en_rd) begin
                  copy_ff <= 1'b1; src_ff <= ROW_W'(e_ff - 1'b1);
               end
               st_ff <= S_VRD;
            end
            S_VRD: st_ff <= S_VWAIT;
            S_VWAIT: begin f1_ff <= va_rd; st_ff <= S_VCMP; end
            S_VCMP: begin
               f2_ff <= va_rd;
               st_ff <= copy_ff ? S_OUT : S_MUL;
            end
            S_MUL: st_ff <= S_DGO;
            S_DGO: st_ff <= S_DIV;
            S_DIV: if (ddone) st_ff <= S_OUT;
            S_OUT: begin
               ov_ff <= 1'b1; ocol_ff <= col_ff; fo_ff <= found_ff;
               last_ff <= (col_ff == COL_W'(NUM_VALUES - 1));
               if (!found_ff) out_ff <= '0;
               else if (copy_ff) out_ff <= f1_ff;
               else if (r > 35'sd2147483647) out_ff <= 32'h7FFF_FFFF;
               else if (r < -35'sd2147483648) out_ff <= 32'h8000_0000;
               else out_ff <= r[31:0];
               if (col_ff == COL_W'(NUM_VALUES - 1)) st_ff <= S_IDLE;
               else begin
                  col_ff <= col_ff + 1'b1;
                  st_ff <= found_ff ? S_VRD : S_OUT;
               end
            end
            default: st_ff <= S_IDLE;
         endcase
      end
      // capture x2 while the probe row is read
      if (st_ff == S_PWAIT) x2_ff <= en_rd;
      if (st_ff == S_MUL) begin
         prod_ff <= 64'(mdf) * 64'(mt);
         neg_ff <= df[32] != tt[32];
      end
   end
endmodule
